@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files of the project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define TARHP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the house clock and reset names.
`define TARHP_ASSERT(lbl, prop, msg) \
  `TARHP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/core/tarhp_pkg.sv @@
// Shared types and constants of the tar header stream parser.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tarhp_pkg;

  // Header block geometry
  localparam logic [8:0] BlockLast = 9'd511;
  localparam logic [8:0] SizeAt    = 9'd124;
  localparam logic [8:0] SizeEnd   = 9'd135;
  localparam logic [8:0] MagicAt   = 9'd257;
  localparam logic [8:0] MagicEnd  = 9'd261;

  // Characters looked at in the header
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharSlash = 8'h2f;

  localparam logic [7:0] MagicText [5] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72};

  // Name skip reported for a "./" prefix
  localparam logic [1:0] DotSkip = 2'd2;

  typedef enum logic [1:0] {
    KindEntry    = 2'd0,
    KindEnd      = 2'd1,
    KindBadMagic = 2'd2
  } result_kind_e;

  // One archive byte as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/core/tar_header_stream_parser.sv @@
// Channel   Handshake                    Payload
// in        in_valid_i / in_stall_o      data_byte_i, last_byte_i
// out       out_valid_o / out_stall_i    result_kind_o, entry_size_o, data_offset_o, name_skip_o
//
// One archive byte per cycle while no stalled result holds the input; each byte passes through
// the input register, and a header's result is registered in the cycle after its last byte is processed.
// The rate is set by the single pass of the per-byte update of the parser state.
// Reset (rst_ni low) clears all parser state; no clearing pass is needed.
// A stalled result stalls the input only when the next byte completes a header.
//
// Top level: input register feeding the parser core. Depends on tarhp_pkg,
// tarhp_in_stage and tarhp_core.
`timescale 1ns / 1ps
`default_nettype none

module tar_header_stream_parser #(
  parameter int ADDRESS_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [35:0]      entry_size_o,
  output logic [31:0]      data_offset_o,
  output logic [1:0]       name_skip_o
);

  tarhp_pkg::item_t in_item;
  tarhp_pkg::item_t held_item;
  logic             held_valid;
  logic             consume;

  assign in_item.data_byte = data_byte_i;
  assign in_item.last_byte = last_byte_i;

  tarhp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .valid_o    (held_valid),
    .item_o     (held_item),
    .consume_i  (consume)
  );

  tarhp_core #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (held_valid),
    .item_i        (held_item),
    .consume_o     (consume),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .entry_size_o  (entry_size_o),
    .data_offset_o (data_offset_o),
    .name_skip_o   (name_skip_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/tarhp_in_stage.sv @@
// Input register of the tar header stream parser: holds one byte transfer.
// Depends on tarhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tarhp_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire tarhp_pkg::item_t item_i,
  output logic                 valid_o,
  output tarhp_pkg::item_t     item_o,
  input  wire logic            consume_i
);

  logic             valid_q, valid_d;
  tarhp_pkg::item_t item_q;
  logic             load;

  // Stall only while a held byte cannot move on
  assign in_stall_o = valid_q && !consume_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on every transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/core/tarhp_core.sv @@
// Parser state, per-byte header logic and the result register.
// Depends on tarhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tarhp_core #(
  parameter int ADDRESS_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire tarhp_pkg::item_t item_i,
  output logic                  consume_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [1:0]            result_kind_o,
  output logic [35:0]           entry_size_o,
  output logic [31:0]           data_offset_o,
  output logic [1:0]            name_skip_o
);

  typedef enum logic [1:0] {
    PhHeader,
    PhData,
    PhStop
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [8:0]              block_pos_q, block_pos_d;
  logic [26:0]             skip_blocks_q, skip_blocks_d;
  logic [35:0]             size_acc_q, size_acc_d;
  logic                    octal_live_q, octal_live_d;
  logic                    magic_ok_q, magic_ok_d;
  logic                    name_empty_q, name_empty_d;
  logic                    dot_prefix_q, dot_prefix_d;
  logic [ADDRESS_BITS-1:0] archive_pos_q, archive_pos_d;

  logic                    out_valid_q;
  logic [1:0]              kind_q, kind_d;
  logic [35:0]             size_q, size_d;
  logic [31:0]             offset_q, offset_d;
  logic [1:0]              skip_q, skip_d;

  logic [7:0]              b;
  logic [8:0]              p;
  logic [36:0]             size_round;
  logic [27:0]             blocks;
  logic [ADDRESS_BITS-1:0] pos_next;
  logic [63:0]             pos_wide;
  logic                    res_fire;
  logic                    out_free;
  logic                    step;

  assign b          = item_i.data_byte;
  assign p          = block_pos_q;
  assign pos_next   = archive_pos_q + 1'b1;
  assign pos_wide   = 64'(pos_next);
  assign size_round = {1'b0, size_acc_q} + 37'(tarhp_pkg::BlockLast);
  assign blocks     = size_round[36:9];

  // Take a byte unless it completes a header and the result slot is busy
  assign res_fire  = (phase_q == PhHeader) && (p == tarhp_pkg::BlockLast);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign step      = valid_i && (!res_fire || out_free);
  assign consume_o = step;

  // Next state and result for the held byte
  always_comb begin
    phase_d       = phase_q;
    skip_blocks_d = skip_blocks_q;
    size_acc_d    = size_acc_q;
    octal_live_d  = octal_live_q;
    magic_ok_d    = magic_ok_q;
    name_empty_d  = name_empty_q;
    dot_prefix_d  = dot_prefix_q;
    kind_d        = tarhp_pkg::KindEntry;
    size_d        = '0;
    offset_d      = '0;
    skip_d        = '0;

    case (phase_q)
      PhHeader: begin
        // Name tests
        if (p == 9'd0) begin
          name_empty_d = (b == tarhp_pkg::CharNul);
          dot_prefix_d = (b == tarhp_pkg::CharDot);
        end else if (p == 9'd1) begin
          dot_prefix_d = dot_prefix_q && (b == tarhp_pkg::CharSlash);
        end
        // Octal size digits until the first non-digit
        if ((p inside {[tarhp_pkg::SizeAt:tarhp_pkg::SizeEnd]}) && octal_live_q) begin
          if (b < tarhp_pkg::CharZero || b > tarhp_pkg::CharSeven) begin
            octal_live_d = 1'b0;
          end else begin
            size_acc_d = {size_acc_q[32:0], 3'(b - tarhp_pkg::CharZero)};
          end
        end
        // Magic compare
        if (p inside {[tarhp_pkg::MagicAt:tarhp_pkg::MagicEnd]}) begin
          if (b != tarhp_pkg::MagicText[3'(p - tarhp_pkg::MagicAt)]) begin
            magic_ok_d = 1'b0;
          end
        end
        // Header complete: classify and clear header flags
        if (res_fire) begin
          if (name_empty_q) begin
            kind_d  = tarhp_pkg::KindEnd;
            phase_d = PhStop;
          end else if (!magic_ok_q) begin
            kind_d  = tarhp_pkg::KindBadMagic;
            phase_d = PhStop;
          end else begin
            size_d   = size_acc_q;
            offset_d = pos_wide[31:0];
            skip_d   = dot_prefix_q ? tarhp_pkg::DotSkip : 2'd0;
            if (blocks == '0) begin
              phase_d = PhHeader;
            end else begin
              phase_d       = PhData;
              skip_blocks_d = blocks[26:0] - 27'd1;
            end
          end
          size_acc_d   = '0;
          octal_live_d = 1'b1;
          magic_ok_d   = 1'b1;
          name_empty_d = 1'b0;
          dot_prefix_d = 1'b0;
        end
      end
      PhData: begin
        // Count down data blocks at each block end
        if (p == tarhp_pkg::BlockLast) begin
          if (skip_blocks_q == '0) begin
            phase_d = PhHeader;
          end else begin
            skip_blocks_d = skip_blocks_q - 27'd1;
          end
        end
      end
      default: begin
        // Stopped: drop bytes until the last-byte flag
      end
    endcase

    block_pos_d   = p + 9'd1;
    archive_pos_d = pos_next;

    // Final archive byte returns the parser state to reset
    if (item_i.last_byte) begin
      phase_d       = PhHeader;
      block_pos_d   = '0;
      skip_blocks_d = '0;
      archive_pos_d = '0;
      size_acc_d    = '0;
      octal_live_d  = 1'b1;
      magic_ok_d    = 1'b1;
      name_empty_d  = 1'b0;
      dot_prefix_d  = 1'b0;
    end
  end

  // Hold parser state; advance on each consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhHeader;
      block_pos_q   <= '0;
      skip_blocks_q <= '0;
      size_acc_q    <= '0;
      octal_live_q  <= 1'b1;
      magic_ok_q    <= 1'b1;
      name_empty_q  <= 1'b0;
      dot_prefix_q  <= 1'b0;
      archive_pos_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (step) begin
        phase_q       <= phase_d;
        block_pos_q   <= block_pos_d;
        skip_blocks_q <= skip_blocks_d;
        size_acc_q    <= size_acc_d;
        octal_live_q  <= octal_live_d;
        magic_ok_q    <= magic_ok_d;
        name_empty_q  <= name_empty_d;
        dot_prefix_q  <= dot_prefix_d;
        archive_pos_q <= archive_pos_d;
      end
      if (step && res_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register when a header completes
  always_ff @(posedge clk_i) begin
    if (step && res_fire) begin
      kind_q   <= kind_d;
      size_q   <= size_d;
      offset_q <= offset_d;
      skip_q   <= skip_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign entry_size_o  = size_q;
  assign data_offset_o = offset_q;
  assign name_skip_o   = skip_q;

endmodule

`default_nettype wire

@@ rtl/core/tarhp_checker.sv @@
// Port-level checks of the tar header stream parser, bound to the top level.
// Depends on tarhp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tarhp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  result_kind_o,
  input wire logic [35:0] entry_size_o,
  input wire logic [31:0] data_offset_o,
  input wire logic [1:0]  name_skip_o
);

  // Hold a stalled result
  `TARHP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o) && $stable(entry_size_o) && $stable(data_offset_o) && $stable(name_skip_o), "stalled result changed")

  // Only defined result codes leave the block
  `TARHP_ASSERT(a_kind_legal, out_valid_o |-> result_kind_o == tarhp_pkg::KindEntry || result_kind_o == tarhp_pkg::KindEnd || result_kind_o == tarhp_pkg::KindBadMagic, "undefined result kind")

  // Stop results carry zero fields
  `TARHP_ASSERT(a_stop_zero, out_valid_o && result_kind_o != tarhp_pkg::KindEntry |-> entry_size_o == 36'd0 && data_offset_o == 32'd0 && name_skip_o == 2'd0, "stop result with nonzero fields")

  // Entry data starts on a block boundary and name skip is 0 or 2
  `TARHP_ASSERT(a_entry_shape, out_valid_o && result_kind_o == tarhp_pkg::KindEntry |-> data_offset_o[8:0] == 9'd0 && (name_skip_o == 2'd0 || name_skip_o == tarhp_pkg::DotSkip), "malformed entry result")

  // Input stalls only behind a stalled result
  `TARHP_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output backpressure")

endmodule

bind tar_header_stream_parser tarhp_checker u_tarhp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_kind_o (result_kind_o),
  .entry_size_o  (entry_size_o),
  .data_offset_o (data_offset_o),
  .name_skip_o   (name_skip_o)
);

`default_nettype wire

@@ sim/tb_tar_header_stream_parser.sv @@
// Self-checking testbench for tar_header_stream_parser: streams tar headers,
// data and stray bytes, and checks each result against a behavioral predictor.
// Depends on tarhp_pkg and the tar_header_stream_parser RTL.
`timescale 1ns / 1ps

module tb_tar_header_stream_parser;
  import tarhp_pkg::*;

  localparam int NumDirRows = 16;
  localparam int RandomResults = 48;
  localparam int RandomBytes = 1550;
  localparam int DrainCycles = 20;
  localparam logic [7:0] CharSpace = 8'h20;

  // Predictor phase of the header walk
  typedef enum logic [1:0] {
    WalkHeader  = 2'd0,
    WalkData    = 2'd1,
    WalkStopped = 2'd2
  } walk_phase_e;

  // Idle and stall mix applied to both channels
  typedef enum int {
    TrafficFree,
    TrafficSenderIdle,
    TrafficReceiverStall,
    TrafficBoth
  } traffic_e;

  typedef struct packed {
    result_kind_e kind;
    logic [35:0]  entry_size;
    logic [31:0]  data_offset;
    logic [1:0]   name_skip;
  } header_result_t;

  // One header to stream: name start, size field, magic damage, last_byte cut
  typedef struct packed {
    logic [7:0]     name0;
    logic [7:0]     name1;
    logic [35:0]    size_val;
    int             size_digits;
    logic [7:0]     size_stop;
    logic [39:0]    magic_xor;
    int             cut;
    bit             typed;
    header_result_t want;
  } header_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [35:0] entry_size_o;
  logic [31:0] data_offset_o;
  logic [1:0]  name_skip_o;

  // Predictor state
  logic [8:0]  blk_pos;
  walk_phase_e walk_phase;
  logic [26:0] blocks_left;
  logic [35:0] size_sum;
  logic        digits_open;
  logic        magic_match;
  logic        name_blank;
  logic        dot_slash;
  logic [31:0] byte_addr;

  header_result_t expected_results [$];
  header_result_t typed_want;
  bit             typed_armed = 1'b0;

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int results_due = 0;
  int results_checked = 0;
  int bytes_parsed = 0;
  int headers_sent = 0;

  // Directed headers; expectations typed in only where obvious
  header_row_t dir_rows [NumDirRows] = '{
    // zero size entry right after reset
    '{8'h61, 8'h00, 36'd0, 11, CharNul, 40'd0, -1, 1'b1,
      '{KindEntry, 36'd0, 32'd512, 2'd0}},
    // "./" name, one data block
    '{CharDot, CharSlash, 36'd512, 11, CharNul, 40'd0, -1, 1'b1,
      '{KindEntry, 36'd512, 32'd1024, DotSkip}},
    // twelve 7s: largest size, data cut short by last_byte
    '{CharDot, 8'h78, 36'hFFFFFFFFF, 12, CharNul, 40'd0, -1, 1'b1,
      '{KindEntry, 36'hFFFFFFFFF, 32'd2048, 2'd0}},
    '{8'h62, 8'h41, 36'd1, 1, CharNul, 40'd0, -1, 1'b1,
      '{KindEntry, 36'd1, 32'd512, 2'd0}},
    // size digits end at an '8', a leading space, and a '/'
    '{8'h63, 8'h00, 36'd10, 3, 8'h38, 40'd0, -1, 1'b0, '0},
    '{8'h64, 8'h00, 36'd15, 0, CharSpace, 40'd0, -1, 1'b0, '0},
    '{8'h65, 8'h00, 36'd7, 2, CharSlash, 40'd0, -1, 1'b0, '0},
    // empty name wins over bad magic
    '{CharNul, 8'h00, 36'd0, 11, CharNul, 40'h0000000020, -1, 1'b1,
      '{KindEnd, 36'd0, 32'd0, 2'd0}},
    '{8'h66, 8'h00, 36'd0, 11, CharNul, 40'h0000000020, -1, 1'b1,
      '{KindBadMagic, 36'd0, 32'd0, 2'd0}},
    '{CharNul, 8'h00, 36'd0, 11, CharNul, 40'd0, -1, 1'b1,
      '{KindEnd, 36'd0, 32'd0, 2'd0}},
    // header cut mid-way: no result
    '{8'h67, 8'h00, 36'd0, 11, CharNul, 40'd0, 300, 1'b0, '0},
    // last_byte on the final header byte still gives the result
    '{8'h68, 8'h00, 36'd100, 3, CharNul, 40'd0, 511, 1'b1,
      '{KindEntry, 36'd100, 32'd512, 2'd0}},
    '{8'h69, 8'h00, 36'd0, 11, CharNul, 40'h0D00000000, -1, 1'b1,
      '{KindBadMagic, 36'd0, 32'd0, 2'd0}},
    '{CharDot, CharSlash, 36'd10, 11, CharSpace, 40'd0, -1, 1'b0, '0},
    '{8'hFF, 8'h00, 36'd0, 12, CharNul, 40'd0, -1, 1'b0, '0},
    '{CharNul, 8'hFF, 36'd0, 11, CharNul, 40'd0, -1, 1'b1,
      '{KindEnd, 36'd0, 32'd0, 2'd0}}
  };

  tar_header_stream_parser #(
    .ADDRESS_BITS(32)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .entry_size_o (entry_size_o),
    .data_offset_o(data_offset_o),
    .name_skip_o  (name_skip_o)
  );

  always #6 clk_i = ~clk_i;

  // Stall the result channel at the current rate
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic void clear_header_scan();
    size_sum = '0;
    digits_open = 1'b1;
    magic_match = 1'b1;
    name_blank = 1'b0;
    dot_slash = 1'b0;
  endfunction

  function automatic void clear_walker();
    blk_pos = '0;
    walk_phase = WalkHeader;
    blocks_left = '0;
    byte_addr = '0;
    clear_header_scan();
  endfunction

  // Advance the predictor by one archive byte
  task automatic step_walker(input logic [7:0] b, input logic last,
                             output bit has_res, output header_result_t res);
    logic [8:0]  p;
    logic [36:0] nblk;
    p = blk_pos;
    has_res = 1'b0;
    res = '0;
    case (walk_phase)
      WalkHeader: begin
        if (p == 9'd0) begin
          name_blank = (b == CharNul);
          dot_slash = (b == CharDot);
        end else if (p == 9'd1) begin
          dot_slash = dot_slash && (b == CharSlash);
        end
        if (p >= SizeAt && p <= SizeEnd && digits_open) begin
          if (b < CharZero || b > CharSeven) digits_open = 1'b0;
          else size_sum = {size_sum[32:0], b[2:0]};
        end
        if (p >= MagicAt && p <= MagicEnd && b != MagicText[p - MagicAt])
          magic_match = 1'b0;
        if (p == BlockLast) begin
          has_res = 1'b1;
          if (name_blank) begin
            res.kind = KindEnd;
            walk_phase = WalkStopped;
          end else if (!magic_match) begin
            res.kind = KindBadMagic;
            walk_phase = WalkStopped;
          end else begin
            nblk = ({1'b0, size_sum} + 37'd511) >> 9;
            res.kind = KindEntry;
            res.entry_size = size_sum;
            res.data_offset = byte_addr + 32'd1;
            res.name_skip = dot_slash ? DotSkip : 2'd0;
            if (nblk == '0) begin
              walk_phase = WalkHeader;
            end else begin
              walk_phase = WalkData;
              blocks_left = 27'(nblk - 37'd1);
            end
          end
          clear_header_scan();
        end
      end
      WalkData: begin
        if (p == BlockLast) begin
          if (blocks_left == '0) walk_phase = WalkHeader;
          else blocks_left = blocks_left - 27'd1;
        end
      end
      default: ;
    endcase
    blk_pos = p + 9'd1;
    byte_addr = byte_addr + 32'd1;
    if (last) clear_walker();
  endtask

  task automatic set_traffic(input traffic_e mode);
    case (mode)
      TrafficFree:          begin idle_pct = 0;  stall_pct = 0;  end
      TrafficSenderIdle:    begin idle_pct = 47; stall_pct = 0;  end
      TrafficReceiverStall: begin idle_pct = 0;  stall_pct = 47; end
      default:              begin idle_pct = 8;  stall_pct = 8;  end
    endcase
  endtask

  // Offer one byte, hold it until the transfer, then predict its result
  task automatic send_byte(input logic [7:0] b, input logic last);
    header_result_t res;
    bit             has_res;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (walk_phase != WalkStopped) bytes_parsed++;
    step_walker(b, last, has_res, res);
    if (has_res) begin
      if (typed_armed) begin
        res = typed_want;
        typed_armed = 1'b0;
      end
      expected_results.push_back(res);
      results_due++;
    end
  endtask

  // Build one 512-byte header around random filler and stream it
  task automatic push_header(input header_row_t r);
    logic [7:0] hdr [512];
    for (int i = 0; i < 512; i++) hdr[i] = 8'($urandom);
    hdr[0] = r.name0;
    hdr[1] = r.name1;
    for (int i = 0; i < 12; i++) begin
      if (i < r.size_digits)
        hdr[SizeAt + i] = CharZero |
          8'((r.size_val >> (3 * (r.size_digits - 1 - i))) & 36'd7);
      else if (i == r.size_digits)
        hdr[SizeAt + i] = r.size_stop;
    end
    for (int i = 0; i < 5; i++)
      hdr[MagicAt + i] = MagicText[i] ^ r.magic_xor[39 - 8 * i -: 8];
    headers_sent++;
    for (int i = 0; i < 512; i++) begin
      send_byte(hdr[i], i == r.cut);
      if (i == r.cut) break;
    end
  endtask

  // Skip entry data or close a stopped archive; cut long data, and at random some short data, with last_byte
  task automatic finish_body();
    int n;
    if (walk_phase == WalkData && (blocks_left > 27'd3 || $urandom_range(0, 9) == 0)) begin
      n = $urandom_range(1, 700);
      repeat (n - 1) send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
    end else if (walk_phase == WalkData) begin
      while (walk_phase == WalkData) send_byte(8'($urandom), 1'b0);
    end else if (walk_phase == WalkStopped) begin
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
    end
  endtask

  // Mostly well-formed headers; the closing one of an archive mostly ends it with an empty name or a cut
  function automatic header_row_t random_row(input bit closing);
    header_row_t r;
    int          pick;
    r = '0;
    r.cut = -1;
    r.name0 = 8'($urandom_range(1, 255));
    r.name1 = 8'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      r.name0 = CharDot;
      if ($urandom_range(0, 1) == 1) r.name1 = CharSlash;
    end
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      r.size_val = {4'($urandom), 32'($urandom)};
      r.size_digits = 12;
    end else begin
      r.size_val = (pick < 20) ? 36'd0 : 36'($urandom_range(1, 2048));
      r.size_digits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(4, 11);
    end
    case ($urandom_range(0, 2))
      0: r.size_stop = CharNul;
      1: r.size_stop = CharSpace;
      default: begin
        r.size_stop = 8'($urandom);
        // push an octal digit out of range
        if (r.size_stop >= CharZero && r.size_stop <= CharSeven)
          r.size_stop = r.size_stop ^ 8'h08;
      end
    endcase
    if ($urandom_range(0, 11) == 0)
      r.magic_xor = 40'(8'($urandom_range(1, 255))) << (8 * $urandom_range(0, 4));
    if ($urandom_range(0, 39) == 0) r.cut = $urandom_range(0, 511);
    if (closing) begin
      case ($urandom_range(0, 4))
        0, 1: r.name0 = CharNul;
        2: r.cut = $urandom_range(0, 511);
        3: r.cut = 511;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [35:0] want,
                               input logic [35:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected 'h%0h, actual 'h%0h", $time, what, want, got);
    end
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    header_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result kind %0d size 'h%0h offset 'h%0h skip %0d",
                 $time, result_kind_o, entry_size_o, data_offset_o, name_skip_o);
      end else begin
        want = expected_results.pop_front();
        compare_field("result_kind", want.kind, result_kind_o);
        compare_field("entry_size", want.entry_size, entry_size_o);
        compare_field("data_offset", want.data_offset, data_offset_o);
        compare_field("name_skip", want.name_skip, name_skip_o);
        results_checked++;
      end
    end
  end

  // Main sequence: reset, directed headers, random archives, drain
  initial begin
    int dir_results;
    int archives;
    int n;
    clear_walker();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      set_traffic(traffic_e'(i % 4));
      typed_armed = dir_rows[i].typed;
      typed_want = dir_rows[i].want;
      push_header(dir_rows[i]);
      typed_armed = 1'b0;
      finish_body();
    end

    dir_results = results_due;
    bytes_parsed = 0;
    archives = 0;
    while (results_due - dir_results < RandomResults || bytes_parsed < RandomBytes) begin
      set_traffic(traffic_e'(archives % 4));
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
        push_header(random_row(k == n - 1));
        finish_body();
      end
      archives++;
    end

    in_valid_i <= 1'b0;
    last_byte_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Streamed %0d headers (%0d random archives, %0d parsed bytes in random part).",
             headers_sent, archives, bytes_parsed);
    $display("Checked %0d results; %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb_tar_header_stream_parser: clean");
    end else begin
      $display("tb_tar_header_stream_parser: errors");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
    $display("tb_tar_header_stream_parser: errors");
    $finish;
  end

endmodule
